FILE: rtl/core/cfa_pkg.sv
package cfa_pkg;

  localparam int OP_BITS = 2;

  typedef enum logic [OP_BITS-1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STS_OK  = 2'd0,
    STS_OVF = 2'd1,
    STS_DZ  = 2'd2
  } status_e;

  // Products issued to the shared multiplier, in issue order.
  typedef enum logic [2:0] {
    PR_AR_BR = 3'd0,
    PR_AI_BI = 3'd1,
    PR_AR_BI = 3'd2,
    PR_AI_BR = 3'd3,
    PR_BR_BR = 3'd4,
    PR_BI_BI = 3'd5
  } prod_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD,
    S_MUL,
    S_DRAIN,
    S_MUL_FIN,
    S_DEN_CHK,
    S_DIV_RE,
    S_DIV_IM,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic  accept;
    logic  load;
    logic  addsub;
    logic  mul_go;
    prod_e mul_sel;
    logic  mul_fin;
    logic  div_zero;
    logic  div_start;
    logic  div_start_im;
    logic  div_write;
    logic  div_write_im;
    logic  emit;
  } dp_cmd_t;

  typedef struct packed {
    logic den_zero;
    logic div_done;
    logic out_full;
  } dp_sts_t;

endpackage

FILE: rtl/core/cfa_intf.sv
interface cfa_in_if #(
  parameter int WORD_BITS = 32
) ();
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] real_part;
  logic signed [WORD_BITS-1:0] imag_part;
  logic                        first_element;
  logic                        last_element;

  modport source (
    output valid, real_part, imag_part, first_element, last_element,
    input  ready
  );
  modport sink (
    input  valid, real_part, imag_part, first_element, last_element,
    output ready
  );
endinterface

interface cfa_out_if #(
  parameter int WORD_BITS = 32
) ();
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] result_real;
  logic signed [WORD_BITS-1:0] result_imag;
  logic [1:0]                  status;

  modport source (
    output valid, result_real, result_imag, status,
    input  ready
  );
  modport sink (
    input  valid, result_real, result_imag, status,
    output ready
  );
endinterface

FILE: rtl/core/cfa_div.sv
module cfa_div #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [2*W:0]     num_i,
  input  logic [2*W-1:0]   den_i,
  output logic             done_o,
  output logic [W:0]       quo_o
);
  localparam int CW   = 3 * W + F + 1;
  localparam int CNTW = $clog2(W + 2);

  logic [CW-1:0]   rem_q, dsh_q;
  logic [W:0]      quo_q;
  logic [CNTW-1:0] cnt_q;
  logic            busy_q, done_q;
  logic            ge;

  // Restoring division, one quotient bit per cycle from bit W down to bit 0.
  assign ge = rem_q >= dsh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNTW'(W + 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNTW'(1);
        if (cnt_q == CNTW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= CW'(num_i) << F;
      dsh_q <= CW'(den_i) << W;
    end else if (busy_q) begin
      rem_q <= ge ? (rem_q - dsh_q) : rem_q;
      quo_q <= {quo_q[W-1:0], ge};
      dsh_q <= dsh_q >> 1;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

FILE: rtl/core/cfa_dp.sv
module cfa_dp #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cfa_pkg::op_e           op_i,
  input  cfa_pkg::dp_cmd_t       cmd_i,
  output cfa_pkg::dp_sts_t       sts_o,
  input  logic signed [W-1:0]    in_real_i,
  input  logic signed [W-1:0]    in_imag_i,
  input  logic                   out_ready_i,
  output logic                   out_valid_o,
  output logic signed [W-1:0]    out_real_o,
  output logic signed [W-1:0]    out_imag_o,
  output logic [1:0]             out_status_o
);
  import cfa_pkg::*;

  localparam int MW = 2 * W + 1;

  logic signed [W-1:0]   acc_re_q, acc_im_q, acc_re_d, acc_im_d;
  status_e               sts_q, sts_d;
  logic signed [W-1:0]   b_re_q, b_im_q;
  logic signed [W-1:0]   ma, mb;
  logic signed [2*W-1:0] prod, p_q;
  prod_e                 p_sel_q;
  logic                  p_vld_q;
  logic signed [MW-1:0]  pext, nre_q, nim_q, den_q;
  logic signed [W:0]     add_re, add_im;
  logic [W:0]            sat_are, sat_aim, sat_mre, sat_mim, sat_div;
  logic                  wr_neg;
  logic [MW-1:0]         div_num;
  logic                  div_done;
  logic [W:0]            quo;
  logic                  out_vld_q;
  logic signed [W-1:0]   out_re_q, out_im_q;
  status_e               out_sts_q;

  function automatic logic [W:0] mag_w1(input logic [W:0] v);
    return v[W] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic [MW-1:0] mag_mw(input logic [MW-1:0] v);
    return v[MW-1] ? (~v + 1'b1) : v;
  endfunction

  // Returns the overflow flag above the clamped word.
  function automatic logic [W:0] sat_word(input logic neg, input logic [MW-1:0] mag);
    logic [MW-1:0] lim;
    logic [W-1:0]  wv;
    logic          ovf;
    lim = neg ? (MW'(1) << (W - 1)) : ((MW'(1) << (W - 1)) - MW'(1));
    ovf = mag > lim;
    wv  = ovf ? lim[W-1:0] : mag[W-1:0];
    wv  = neg ? (~wv + 1'b1) : wv;
    return {ovf, wv};
  endfunction

  function automatic status_e raise_ovf(input status_e cur, input logic ovf);
    return (ovf && cur == STS_OK) ? STS_OVF : cur;
  endfunction

  always_comb begin
    unique case (cmd_i.mul_sel)
      PR_AR_BR: begin ma = acc_re_q; mb = b_re_q; end
      PR_AI_BI: begin ma = acc_im_q; mb = b_im_q; end
      PR_AR_BI: begin ma = acc_re_q; mb = b_im_q; end
      PR_AI_BR: begin ma = acc_im_q; mb = b_re_q; end
      PR_BR_BR: begin ma = b_re_q;   mb = b_re_q; end
      PR_BI_BI: begin ma = b_im_q;   mb = b_im_q; end
      default:  begin ma = acc_re_q; mb = b_re_q; end
    endcase
  end

  assign prod = ma * mb;
  assign pext = MW'(p_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
      p_sel_q <= PR_AR_BR;
    end else begin
      p_vld_q <= cmd_i.mul_go;
      p_sel_q <= cmd_i.mul_sel;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      b_re_q <= in_real_i;
      b_im_q <= in_imag_i;
    end
    if (cmd_i.mul_go) begin
      p_q <= prod;
    end
    if (p_vld_q) begin
      unique case (p_sel_q)
        PR_AR_BR: nre_q <= pext;
        PR_AI_BI: nre_q <= (op_i == OP_DIV) ? (nre_q + pext) : (nre_q - pext);
        PR_AR_BI: nim_q <= (op_i == OP_DIV) ? -pext : pext;
        PR_AI_BR: nim_q <= nim_q + pext;
        PR_BR_BR: den_q <= pext;
        PR_BI_BI: den_q <= den_q + pext;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (op_i == OP_SUB) begin
      add_re = (W + 1)'(acc_re_q) - (W + 1)'(b_re_q);
      add_im = (W + 1)'(acc_im_q) - (W + 1)'(b_im_q);
    end else begin
      add_re = (W + 1)'(acc_re_q) + (W + 1)'(b_re_q);
      add_im = (W + 1)'(acc_im_q) + (W + 1)'(b_im_q);
    end
  end

  assign sat_are = sat_word(add_re[W], MW'(mag_w1(add_re)));
  assign sat_aim = sat_word(add_im[W], MW'(mag_w1(add_im)));
  assign sat_mre = sat_word(nre_q[MW-1], mag_mw(nre_q) >> F);
  assign sat_mim = sat_word(nim_q[MW-1], mag_mw(nim_q) >> F);
  assign wr_neg  = cmd_i.div_write_im ? nim_q[MW-1] : nre_q[MW-1];
  assign sat_div = sat_word(wr_neg, MW'(quo));
  assign div_num = mag_mw(cmd_i.div_start_im ? nim_q : nre_q);

  cfa_div #(
    .W (W),
    .F (F)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (den_q[2*W-1:0]),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  always_comb begin
    acc_re_d = acc_re_q;
    acc_im_d = acc_im_q;
    sts_d    = sts_q;
    priority if (cmd_i.load) begin
      acc_re_d = in_real_i;
      acc_im_d = in_imag_i;
      sts_d    = STS_OK;
    end else if (cmd_i.addsub) begin
      acc_re_d = sat_are[W-1:0];
      acc_im_d = sat_aim[W-1:0];
      sts_d    = raise_ovf(sts_q, sat_are[W] | sat_aim[W]);
    end else if (cmd_i.mul_fin) begin
      acc_re_d = sat_mre[W-1:0];
      acc_im_d = sat_mim[W-1:0];
      sts_d    = raise_ovf(sts_q, sat_mre[W] | sat_mim[W]);
    end else if (cmd_i.div_zero) begin
      // A zero element also zeroes both numerators, so both parts clear.
      acc_re_d = '0;
      acc_im_d = '0;
      sts_d    = STS_DZ;
    end else if (cmd_i.div_write) begin
      if (cmd_i.div_write_im) begin
        acc_im_d = sat_div[W-1:0];
      end else begin
        acc_re_d = sat_div[W-1:0];
      end
      sts_d = raise_ovf(sts_q, sat_div[W]);
    end else begin
      sts_d = sts_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_re_q  <= '0;
      acc_im_q  <= '0;
      sts_q     <= STS_OK;
      out_vld_q <= 1'b0;
    end else begin
      acc_re_q <= acc_re_d;
      acc_im_q <= acc_im_d;
      sts_q    <= sts_d;
      if (cmd_i.emit) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_re_q  <= acc_re_q;
      out_im_q  <= acc_im_q;
      out_sts_q <= sts_q;
    end
  end

  assign sts_o.den_zero = (den_q == '0);
  assign sts_o.div_done = div_done;
  assign sts_o.out_full = out_vld_q & ~out_ready_i;

  assign out_valid_o  = out_vld_q;
  assign out_real_o   = out_re_q;
  assign out_imag_o   = out_im_q;
  assign out_status_o = out_sts_q;

endmodule

FILE: rtl/core/cfa_seq.sv
module cfa_seq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfa_pkg::op_e     op_i,
  input  logic             in_valid_i,
  input  logic             in_first_i,
  input  logic             in_last_i,
  output logic             in_ready_o,
  input  cfa_pkg::dp_sts_t sts_i,
  output cfa_pkg::dp_cmd_t cmd_o
);
  import cfa_pkg::*;

  state_e state_q, state_d;
  prod_e  step_q, step_d;
  logic   last_q, last_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= PR_AR_BR;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      last_q  <= last_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    last_d     = last_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          last_d       = in_last_i;
          if (in_first_i) begin
            cmd_o.load = 1'b1;
            state_d    = in_last_i ? S_EMIT : S_IDLE;
          end else if (op_i == OP_ADD || op_i == OP_SUB) begin
            state_d = S_ADD;
          end else begin
            state_d = S_MUL;
            step_d  = PR_AR_BR;
          end
        end
      end
      S_ADD: begin
        cmd_o.addsub = 1'b1;
        state_d      = last_q ? S_EMIT : S_IDLE;
      end
      S_MUL: begin
        cmd_o.mul_go  = 1'b1;
        cmd_o.mul_sel = step_q;
        if ((op_i == OP_MUL && step_q == PR_AI_BR) || step_q == PR_BI_BI) begin
          state_d = S_DRAIN;
        end else begin
          step_d = prod_e'(step_q + 3'd1);
        end
      end
      S_DRAIN: begin
        state_d = (op_i == OP_MUL) ? S_MUL_FIN : S_DEN_CHK;
      end
      S_MUL_FIN: begin
        cmd_o.mul_fin = 1'b1;
        state_d       = last_q ? S_EMIT : S_IDLE;
      end
      S_DEN_CHK: begin
        if (sts_i.den_zero) begin
          cmd_o.div_zero = 1'b1;
          state_d        = last_q ? S_EMIT : S_IDLE;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV_RE;
        end
      end
      S_DIV_RE: begin
        if (sts_i.div_done) begin
          cmd_o.div_write    = 1'b1;
          cmd_o.div_start    = 1'b1;
          cmd_o.div_start_im = 1'b1;
          state_d            = S_DIV_IM;
        end
      end
      S_DIV_IM: begin
        if (sts_i.div_done) begin
          cmd_o.div_write    = 1'b1;
          cmd_o.div_write_im = 1'b1;
          state_d            = last_q ? S_EMIT : S_IDLE;
        end
      end
      S_EMIT: begin
        if (!sts_i.out_full) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/complex_fold_accumulator.sv
// A first element is loaded directly; add and subtract fold in one saturating step;
// multiply issues four products through one shared multiplier, then saturates;
// divide issues six products, checks the divisor and runs the bit-serial divider twice.
// A last element also loads the output register; items are taken one at a time.
// Reset is asynchronous, active low: it clears the accumulator, the status, the operation
// register (add) and all control state.
module complex_fold_accumulator #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cfa_pkg::OP_BITS-1:0]   cfg_wdata_i,
  cfa_in_if.sink                        in_i,
  cfa_out_if.source                     out_o
);
  import cfa_pkg::*;

  op_e     op_q;
  dp_cmd_t cmd;
  dp_sts_t dp_sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q <= OP_ADD;
    end else if (cfg_we_i) begin
      op_q <= op_e'(cfg_wdata_i);
    end
  end

  cfa_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (op_q),
    .in_valid_i (in_i.valid),
    .in_first_i (in_i.first_element),
    .in_last_i  (in_i.last_element),
    .in_ready_o (in_i.ready),
    .sts_i      (dp_sts),
    .cmd_o      (cmd)
  );

  cfa_dp #(
    .W (WORD_BITS),
    .F (FRAC_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .op_i         (op_q),
    .cmd_i        (cmd),
    .sts_o        (dp_sts),
    .in_real_i    (in_i.real_part),
    .in_imag_i    (in_i.imag_part),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .out_real_o   (out_o.result_real),
    .out_imag_o   (out_o.result_imag),
    .out_status_o (out_o.status)
  );

endmodule

FILE: rtl/core/cfa_checker.sv
module cfa_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       in_first_i,
  input logic       in_last_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [1:0] out_status_i
);
  import cfa_pkg::*;

  // An item that opens and closes a list comes back unchanged with a clean status.
  a_single_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && in_first_i && in_last_i && !out_valid_i)
    |-> ##2 (out_valid_i && out_status_i == STS_OK))
    else $error("single-element list did not return a clean result");

  // Folding an element always leaves the block busy in the cycle after it is taken.
  a_fold_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && !in_first_i) |=> !in_ready_i)
    else $error("block ready right after a folded element");

  // A new result follows a cycle in which the block was not taking items.
  a_emit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result appeared without a busy cycle before it");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_status_i <= STS_DZ)
    else $error("undefined status code on the output");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("result dropped while stalled");

endmodule

bind complex_fold_accumulator cfa_checker u_cfa_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_first_i   (in_i.first_element),
  .in_last_i    (in_i.last_element),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_status_i (out_o.status)
);

FILE: sim/complex_fold_accumulator_test.sv
`timescale 1ns / 100ps

module complex_fold_accumulator_test;
  import cfa_pkg::*;

  localparam int WORD_BITS   = 32;
  localparam int FRAC_BITS   = 16;
  localparam int SETTLE      = 100;
  localparam int LONG_HOLD   = 400;
  localparam int CYCLE_LIMIT = 400000;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [127:0]         wide_t;

  localparam wide_t WORD_MAX = (wide_t'(1) <<< (WORD_BITS - 1)) - 1;
  localparam wide_t WORD_MIN = -(wide_t'(1) <<< (WORD_BITS - 1));

  typedef struct packed {
    word_t   re;
    word_t   im;
    status_e sts;
  } fold_result_t;

  class fold_scoreboard;
    op_e          operation;
    word_t        acc_re;
    word_t        acc_im;
    status_e      sticky;
    fold_result_t expected_q[$];
    int           errors;

    function new();
      operation = OP_ADD;
      acc_re    = '0;
      acc_im    = '0;
      sticky    = STS_OK;
      errors    = 0;
    endfunction

    function word_t clamp_word(wide_t v, inout bit ovf);
      if (v > WORD_MAX) begin
        ovf = 1'b1;
        return WORD_MAX[WORD_BITS-1:0];
      end
      if (v < WORD_MIN) begin
        ovf = 1'b1;
        return WORD_MIN[WORD_BITS-1:0];
      end
      return v[WORD_BITS-1:0];
    endfunction

    function wide_t shr_toward_zero(wide_t v);
      return (v < 0) ? -((-v) >>> FRAC_BITS) : (v >>> FRAC_BITS);
    endfunction

    function word_t bound_of(wide_t num);
      if (num > 0) return WORD_MAX[WORD_BITS-1:0];
      if (num < 0) return WORD_MIN[WORD_BITS-1:0];
      return '0;
    endfunction

    function void fold_element(word_t el_re, word_t el_im);
      wide_t ar, ai, br, bi, nr, ni, den;
      bit    ovf;
      ar  = acc_re;
      ai  = acc_im;
      br  = el_re;
      bi  = el_im;
      ovf = 1'b0;
      case (operation)
        OP_ADD: begin
          nr = ar + br;
          ni = ai + bi;
        end
        OP_SUB: begin
          nr = ar - br;
          ni = ai - bi;
        end
        OP_MUL: begin
          nr = shr_toward_zero(ar * br - ai * bi);
          ni = shr_toward_zero(ar * bi + ai * br);
        end
        default: begin
          den = br * br + bi * bi;
          nr  = ar * br + ai * bi;
          ni  = ai * br - ar * bi;
          if (den == 0) begin
            acc_re = bound_of(nr);
            acc_im = bound_of(ni);
            sticky = STS_DZ;
            return;
          end
          nr = (nr <<< FRAC_BITS) / den;
          ni = (ni <<< FRAC_BITS) / den;
        end
      endcase
      acc_re = clamp_word(nr, ovf);
      acc_im = clamp_word(ni, ovf);
      if (ovf && sticky == STS_OK) sticky = STS_OVF;
    endfunction

    function void note_item(word_t re, word_t im, bit first, bit last);
      fold_result_t res;
      if (first) begin
        acc_re = re;
        acc_im = im;
        sticky = STS_OK;
      end else begin
        fold_element(re, im);
      end
      if (last) begin
        res.re  = acc_re;
        res.im  = acc_im;
        res.sts = sticky;
        expected_q.push_back(res);
      end
    endfunction

    function void check_result(word_t re, word_t im, logic [1:0] sts);
      fold_result_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result: real %h imag %h status %0d", $time, re, im, sts);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (re !== want.re) begin
        $display("%0t: result_real expected %h actual %h", $time, want.re, re);
        errors++;
      end
      if (im !== want.im) begin
        $display("%0t: result_imag expected %h actual %h", $time, want.im, im);
        errors++;
      end
      if (sts !== want.sts) begin
        $display("%0t: status expected %0d actual %0d", $time, want.sts, sts);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [OP_BITS-1:0]  cfg_wdata_i;
  int                  hold_left = 0;
  bit                  calm = 1'b0;
  fold_scoreboard      sb = new();

  cfa_in_if  #(.WORD_BITS(WORD_BITS)) in_if ();
  cfa_out_if #(.WORD_BITS(WORD_BITS)) out_if ();

  complex_fold_accumulator #(
    .WORD_BITS(WORD_BITS),
    .FRAC_BITS(FRAC_BITS)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always #6 clk_i = ~clk_i;

  task automatic send_item(input word_t re, input word_t im, input bit first, input bit last);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.real_part     <= re;
    in_if.imag_part     <= im;
    in_if.first_element <= first;
    in_if.last_element  <= last;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.note_item(re, im, first, last);
  endtask

  task automatic release_input();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_operation(input op_e op);
    release_input();
    wait_drained();
    repeat (SETTLE) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= op;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.operation = op;
  endtask

  function automatic word_t random_part();
    word_t v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0:       v = 32'h7fff_ffff;
          1:       v = 32'h8000_0000;
          2:       v = 32'h0000_0000;
          3:       v = 32'h0000_0001;
          default: v = 32'hffff_ffff;
        endcase
      end
      1, 2: v = $urandom();
      3:    v = $urandom_range(0, 32'h0000_ffff);
      default: v = $urandom_range(0, 32'h0008_0000);
    endcase
    if ($urandom_range(0, 1) == 1) v = -v;
    return v;
  endfunction

  task automatic run_random_items(input op_e op, input int n_items);
    int    sent;
    int    len;
    word_t re;
    word_t im;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 85) begin
        len = $urandom_range(1, 5);
        for (int k = 0; k < len; k++) begin
          re = random_part();
          im = random_part();
          if (op == OP_DIV && k > 0 && $urandom_range(0, 19) == 0) begin
            re = '0;
            im = '0;
          end
          send_item(re, im, k == 0, k == len - 1);
        end
        sent += len;
      end else begin
        send_item(random_part(), random_part(),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        sent++;
      end
    end
  endtask

  initial begin
    int stall_left;
    stall_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        sb.check_result(out_if.result_real, out_if.result_imag, out_if.status);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 7) - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("complex_fold_accumulator_test: errors");
    $finish;
  end

  initial begin
    rst_ni              <= 1'b0;
    cfg_we_i            <= 1'b0;
    cfg_wdata_i         <= OP_ADD;
    in_if.valid         <= 1'b0;
    in_if.real_part     <= '0;
    in_if.imag_part     <= '0;
    in_if.first_element <= 1'b0;
    in_if.last_element  <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // After reset the operation is add and the accumulator is zero.
    send_item(32'h0001_0000, 32'hffff_0000, 1'b0, 1'b1);
    send_item(32'h7fff_ffff, 32'h8000_0000, 1'b1, 1'b1);
    send_item(32'h7fff_ffff, 32'h8000_0000, 1'b1, 1'b0);
    send_item(32'h0000_0001, 32'hffff_ffff, 1'b0, 1'b1);

    write_operation(OP_SUB);
    send_item(32'h8000_0000, 32'h7fff_ffff, 1'b1, 1'b0);
    send_item(32'h0000_0001, 32'hffff_ffff, 1'b0, 1'b1);
    // A list with no first element keeps folding and keeps the sticky status.
    send_item(32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1);

    write_operation(OP_MUL);
    send_item(32'h0002_0000, 32'h0003_0000, 1'b1, 1'b0);
    send_item(32'hfffe_8000, 32'h0000_8000, 1'b0, 1'b1);
    send_item(32'h8000_0000, 32'h8000_0000, 1'b1, 1'b0);
    send_item(32'h8000_0000, 32'h8000_0000, 1'b0, 1'b1);
    send_item(32'hffff_ffff, 32'h0000_0000, 1'b1, 1'b0);
    send_item(32'h0000_0001, 32'h0000_0000, 1'b0, 1'b1);

    write_operation(OP_DIV);
    send_item(32'h0003_0000, 32'h0004_0000, 1'b1, 1'b0);
    send_item(32'h0001_0000, 32'h0002_0000, 1'b0, 1'b1);
    // Overflow first, then a zero divisor, which outranks it.
    send_item(32'h7fff_ffff, 32'h0000_0000, 1'b1, 1'b0);
    send_item(32'h0000_0001, 32'h0000_0000, 1'b0, 1'b0);
    send_item(32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1);
    send_item(32'hffff_ffff, 32'h0000_0000, 1'b1, 1'b0);
    send_item(32'h0003_0000, 32'h0000_0000, 1'b0, 1'b1);

    for (int p = 0; p < 12; p++) begin
      write_operation(op_e'(p % 4));
      calm = (p >= 10);
      if (p == 1) begin
        // The receiver holds off while items keep coming, so the block backs up.
        hold_left = LONG_HOLD;
        run_random_items(op_e'(p % 4), 40);
      end else if (p == 5) begin
        run_random_items(op_e'(p % 4), 20);
        release_input();
        wait_drained();
        run_random_items(op_e'(p % 4), 20);
      end else begin
        run_random_items(op_e'(p % 4), 40);
      end
    end

    release_input();
    wait_drained();
    repeat (SETTLE) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("complex_fold_accumulator_test: clean");
    end else begin
      $display("complex_fold_accumulator_test: errors");
    end
    $finish;
  end

endmodule
